// ===== sv/ljpf_pkg.sv =====
// ljpf_pkg: shared types and constants of the lennard-jones pair force block
// no dependencies
`timescale 1ns / 1ps

package ljpf_pkg;

    // working format: 32 fraction bits, magnitudes capped below 2^62
    localparam int WORK_FRAC = 32;
    localparam int OUT_FRAC  = 24;
    localparam int FAR_BITS  = 30;
    localparam logic [63:0] CAP_W = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_W = 64'h0000_0001_0000_0000;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_CUTOFF_SQ    = 2'd0;
    localparam logic [1:0] REG_SIGMA_POW6   = 2'd1;
    localparam logic [1:0] REG_ENERGY_SHIFT = 2'd2;
    localparam logic [1:0] REG_FORCE_SCALE  = 2'd3;

    // reset values of the registers
    localparam logic [31:0] RST_CUTOFF_SQ    = 32'd2195456;
    localparam logic [31:0] RST_SIGMA_POW6   = 32'd10108207;
    localparam logic [31:0] RST_ENERGY_SHIFT = 32'hFFFF_FEF4;
    localparam logic [31:0] RST_FORCE_SCALE  = 32'd43778;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [31:0] cutoff_sq;
        logic [31:0] sigma_pow6;
        logic [31:0] energy_shift;
        logic [31:0] force_scale;
    } cfg_t;

    // one classified pair as it travels from front to back
    typedef struct packed {
        logic [2:0][FAR_BITS-1:0] mag;
        logic [2:0]               neg;
        logic [63:0]              r2;
        logic                     in_range;
        logic                     last;
    } pair_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== sv/ljpf_queue.sv =====
// ljpf_queue: short fifo of classified pairs between front and back
// depends on ljpf_pkg
`timescale 1ns / 1ps

module ljpf_queue
    import ljpf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  pair_t     push_data,
    input  logic      pop,
    output pair_t     pop_data,
    output q_status_t status
);

    localparam int PW = $clog2(QDEPTH);

    pair_t           mem_reg [QDEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [PW:0]     count_reg;

    assign status.full  = (count_reg == (PW+1)'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(QDEPTH-1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(QDEPTH-1)) ? '0 : rptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== sv/ljpf_front.sv =====
// ljpf_front: takes pair requests, forms dr, squared distance and cutoff class
// depends on ljpf_pkg
`timescale 1ns / 1ps

module ljpf_front
    import ljpf_pkg::*;
#(
    parameter int IN_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [8:0][31:0] in_data,
    input  logic        in_last,
    input  logic [31:0] cutoff_sq,
    output logic        push,
    output pair_t       push_data,
    input  q_status_t   q_status
);

    typedef enum logic [1:0] {F_IDLE, F_DIFF, F_SQ, F_PUSH} fstate_t;

    fstate_t                 state_reg;
    logic [8:0][31:0]        item_reg;
    logic                    last_reg;
    logic [2:0][FAR_BITS-1:0] mag_reg;
    logic [2:0]              neg_reg;
    logic                    far_reg;
    logic [63:0]             r2_reg;
    logic [1:0]              cnt_reg;

    logic signed [33:0]      dr [3];
    logic [33:0]             dmag [3];
    logic [FAR_BITS-1:0]     sq_op;
    logic [2*FAR_BITS-1:0]   sq_sq;
    logic [63:0]             cut_scaled;

    // per-axis difference home - (nbr + image)
    always_comb begin
        for (int m = 0; m < 3; m++) begin
            dr[m] = {{2{item_reg[m][31]}}, item_reg[m]}
                  - ({{2{item_reg[3+m][31]}}, item_reg[3+m]}
                  +  {{2{item_reg[6+m][31]}}, item_reg[6+m]});
            dmag[m] = dr[m][33] ? 34'(-dr[m]) : 34'(dr[m]);
        end
    end

    always_comb begin
        case (cnt_reg)
            2'd0:    sq_op = mag_reg[0];
            2'd1:    sq_op = mag_reg[1];
            default: sq_op = mag_reg[2];
        endcase
        sq_sq = sq_op * sq_op;
    end

    assign cut_scaled = {32'd0, cutoff_sq} << IN_FRAC_BITS;
    assign in_ready   = (state_reg == F_IDLE);
    assign push       = (state_reg == F_PUSH) && !q_status.full;

    always_comb begin
        push_data.mag      = mag_reg;
        push_data.neg      = neg_reg;
        push_data.r2       = r2_reg;
        push_data.in_range = !far_reg && (r2_reg != '0) && (r2_reg <= cut_scaled);
        push_data.last     = last_reg;
    end

    // sequencer: capture, difference, three squares, hand over
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (in_valid) begin
                        item_reg  <= in_data;
                        last_reg  <= in_last;
                        state_reg <= F_DIFF;
                    end
                end
                F_DIFF: begin
                    far_reg <= 1'b0;
                    for (int m = 0; m < 3; m++) begin
                        mag_reg[m] <= dmag[m][FAR_BITS-1:0];
                        neg_reg[m] <= dr[m][33];
                        if (|dmag[m][33:FAR_BITS]) begin
                            far_reg <= 1'b1;
                        end
                    end
                    r2_reg    <= '0;
                    cnt_reg   <= '0;
                    state_reg <= F_SQ;
                end
                F_SQ: begin
                    r2_reg  <= r2_reg + {4'd0, sq_sq};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 2'd2) begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!q_status.full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/ljpf_back.sv =====
// ljpf_back: reciprocal, shared multiplier sequence and saturating accumulation
// depends on ljpf_pkg
`timescale 1ns / 1ps

module ljpf_back
    import ljpf_pkg::*;
#(
    parameter int IN_FRAC_BITS = 16,
    parameter int ACC_WIDTH    = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  pair_t                q_data,
    input  q_status_t            q_status,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ACC_WIDTH-1:0] force_x,
    output logic [ACC_WIDTH-1:0] force_y,
    output logic [ACC_WIDTH-1:0] force_z,
    output logic [ACC_WIDTH-1:0] energy,
    output logic                 saturated
);

    localparam int DIV_K    = WORK_FRAC + 2*IN_FRAC_BITS;
    localparam int CW       = $clog2(DIV_K + 1);
    localparam int FM_SHIFT = IN_FRAC_BITS + WORK_FRAC - OUT_FRAC;
    localparam int UP_SHIFT = WORK_FRAC - IN_FRAC_BITS;
    localparam int HALF_SH  = WORK_FRAC - OUT_FRAC + 1;
    localparam logic [63:0] ACC_MAX64 = 64'((65'd1 << (ACC_WIDTH-1)) - 65'd1);
    localparam logic [ACC_WIDTH-1:0] AMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] AMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic [63:0] K12_LIM = CAP_W / 12;
    localparam logic [63:0] SIX_W   = ONE_W * 6;

    // multiplier operation codes
    localparam logic [3:0] OP_I2 = 4'd0;
    localparam logic [3:0] OP_I3 = 4'd1;
    localparam logic [3:0] OP_R6 = 4'd2;
    localparam logic [3:0] OP_PM = 4'd3;
    localparam logic [3:0] OP_G1 = 4'd4;
    localparam logic [3:0] OP_G2 = 4'd5;
    localparam logic [3:0] OP_G3 = 4'd6;
    localparam logic [3:0] OP_FX = 4'd7;
    localparam logic [3:0] OP_FY = 4'd8;
    localparam logic [3:0] OP_FZ = 4'd9;

    typedef enum logic [2:0] {B_IDLE, B_DIV, B_MUL, B_MSH, B_ACC, B_EMIT} bstate_t;

    bstate_t         state_reg;
    pair_t           ent_reg;
    logic [63:0]     rem_reg, quo_reg;
    logic [CW-1:0]   cnt_reg;
    logic [63:0]     inv_reg, ix_reg, r6_reg, pm_reg, g_reg;
    logic [63:0]     fm_reg [3];
    logic [3:0]      op_reg;
    logic [1:0]      pp_reg;
    logic [127:0]    prod_reg;
    logic            psat_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg [4];
    logic            sat_seen_reg;
    logic            out_valid_reg;
    logic [ACC_WIDTH-1:0] out_reg [4];
    logic            out_sat_reg;

    // saturating add, returns {flag, sum}
    function automatic logic [ACC_WIDTH:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                   input logic [ACC_WIDTH-1:0] b);
        logic [ACC_WIDTH:0] s;
        s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            return {1'b1, s[ACC_WIDTH] ? AMIN : AMAX};
        end
        return {1'b0, s[ACC_WIDTH-1:0]};
    endfunction

    // divider step
    logic        div_first;
    logic [63:0] rem_sh, rem_n, quo_n;
    logic        div_ge;
    always_comb begin
        div_first = (cnt_reg == CW'(DIV_K));
        rem_sh    = {rem_reg[62:0], div_first};
        div_ge    = (rem_sh >= ent_reg.r2);
        rem_n     = div_ge ? rem_sh - ent_reg.r2 : rem_sh;
        quo_n     = {quo_reg[62:0], div_ge};
    end

    // derived terms of r6
    logic signed [63:0] t_s, kt_s;
    logic [63:0]        t_mag, kt_mag, k12;
    logic               k12_sat;
    always_comb begin
        t_s     = $signed(r6_reg) - $signed(ONE_W);
        t_mag   = t_s[63] ? 64'(-t_s) : 64'(t_s);
        k12_sat = (r6_reg > K12_LIM);
        k12     = k12_sat ? CAP_W : 64'(r6_reg * 64'd12);
        kt_s    = $signed(k12) - $signed(SIX_W);
        kt_mag  = kt_s[63] ? 64'(-kt_s) : 64'(kt_s);
    end

    // operand selection for the shared multiplier
    logic [63:0] op_a, op_b, s6, sc;
    assign s6 = {32'd0, cfg.sigma_pow6} << UP_SHIFT;
    assign sc = {32'd0, cfg.force_scale} << UP_SHIFT;
    always_comb begin
        case (op_reg)
            OP_I2:   begin op_a = inv_reg; op_b = inv_reg; end
            OP_I3:   begin op_a = ix_reg;  op_b = inv_reg; end
            OP_R6:   begin op_a = s6;      op_b = ix_reg;  end
            OP_PM:   begin op_a = r6_reg;  op_b = t_mag;   end
            OP_G1:   begin op_a = sc;      op_b = r6_reg;  end
            OP_G2:   begin op_a = g_reg;   op_b = inv_reg; end
            OP_G3:   begin op_a = g_reg;   op_b = kt_mag;  end
            OP_FX:   begin op_a = {34'd0, ent_reg.mag[0]}; op_b = g_reg; end
            OP_FY:   begin op_a = {34'd0, ent_reg.mag[1]}; op_b = g_reg; end
            default: begin op_a = {34'd0, ent_reg.mag[2]}; op_b = g_reg; end
        endcase
    end

    // one 32x32 partial product per cycle
    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_term;
    always_comb begin
        a_half = pp_reg[0] ? op_a[63:32] : op_a[31:0];
        b_half = pp_reg[1] ? op_b[63:32] : op_b[31:0];
        pp     = a_half * b_half;
        case (pp_reg)
            2'd0:    pp_term = {64'd0, pp};
            2'd3:    pp_term = {pp, 64'd0};
            default: pp_term = {32'd0, pp, 32'd0};
        endcase
    end

    // shift and cap of the full product
    logic         op_fm;
    logic [127:0] shifted;
    logic [63:0]  cap, m_res;
    logic         m_sat;
    always_comb begin
        op_fm   = (op_reg == OP_FX) || (op_reg == OP_FY) || (op_reg == OP_FZ);
        shifted = op_fm ? (prod_reg >> FM_SHIFT) : (prod_reg >> WORK_FRAC);
        cap     = op_fm ? ACC_MAX64 : CAP_W;
        m_sat   = (|shifted[127:64]) || (shifted[63:0] > cap);
        m_res   = m_sat ? cap : shifted[63:0];
    end

    // energy and force terms of the pair
    logic signed [63:0] esh, pm_s, e_s;
    logic [63:0]        e_mag, half;
    logic               half_sat;
    logic [ACC_WIDTH-1:0] term [4];
    logic [ACC_WIDTH:0]   sum [4];
    logic                 add_sat;
    always_comb begin
        esh      = $signed({{32{cfg.energy_shift[31]}}, cfg.energy_shift}) <<< UP_SHIFT;
        pm_s     = t_s[63] ? -$signed(pm_reg) : $signed(pm_reg);
        e_s      = pm_s - esh;
        e_mag    = e_s[63] ? 64'(-e_s) : 64'(e_s);
        half     = e_mag >> HALF_SH;
        half_sat = (half > ACC_MAX64);
        if (half_sat) begin
            half = ACC_MAX64;
        end
        for (int m = 0; m < 3; m++) begin
            term[m] = (ent_reg.neg[m] != kt_s[63]) ? ACC_WIDTH'(-fm_reg[m])
                                                   : fm_reg[m][ACC_WIDTH-1:0];
        end
        term[3] = e_s[63] ? ACC_WIDTH'(-half) : half[ACC_WIDTH-1:0];
        add_sat = 1'b0;
        for (int m = 0; m < 4; m++) begin
            sum[m]  = sat_add(acc_reg[m], term[m]);
            add_sat = add_sat | sum[m][ACC_WIDTH];
        end
    end

    assign pop       = (state_reg == B_IDLE) && !q_status.empty;
    assign out_valid = out_valid_reg;
    assign force_x   = out_reg[0];
    assign force_y   = out_reg[1];
    assign force_z   = out_reg[2];
    assign energy    = out_reg[3];
    assign saturated = out_sat_reg;

    // sequencer of one pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            sat_seen_reg  <= 1'b0;
            for (int m = 0; m < 4; m++) begin
                acc_reg[m] <= '0;
            end
        end else begin
            // result taken; the emit state handles its own valid
            if (out_ready && (state_reg != B_EMIT)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!q_status.empty) begin
                        ent_reg  <= q_data;
                        psat_reg <= 1'b0;
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        cnt_reg  <= CW'(DIV_K);
                        if (q_data.in_range) begin
                            state_reg <= B_DIV;
                        end else if (q_data.last) begin
                            state_reg <= B_EMIT;
                        end
                    end
                end
                B_DIV: begin
                    rem_reg <= rem_n;
                    quo_reg <= quo_n;
                    cnt_reg <= cnt_reg - 1'b1;
                    op_reg  <= OP_I2;
                    pp_reg  <= '0;
                    prod_reg <= '0;
                    if (quo_n > CAP_W) begin
                        inv_reg   <= CAP_W;
                        psat_reg  <= 1'b1;
                        state_reg <= B_MUL;
                    end else if (cnt_reg == '0) begin
                        inv_reg   <= quo_n;
                        state_reg <= B_MUL;
                    end
                end
                B_MUL: begin
                    prod_reg <= prod_reg + pp_term;
                    pp_reg   <= pp_reg + 1'b1;
                    if (pp_reg == 2'd3) begin
                        state_reg <= B_MSH;
                    end
                end
                B_MSH: begin
                    psat_reg <= psat_reg | m_sat;
                    case (op_reg)
                        OP_I2, OP_I3:        ix_reg    <= m_res;
                        OP_R6:               r6_reg    <= m_res;
                        OP_PM:               pm_reg    <= m_res;
                        OP_G1, OP_G2, OP_G3: g_reg     <= m_res;
                        OP_FX:               fm_reg[0] <= m_res;
                        OP_FY:               fm_reg[1] <= m_res;
                        default:             fm_reg[2] <= m_res;
                    endcase
                    pp_reg   <= '0;
                    prod_reg <= '0;
                    if (op_reg == OP_FZ) begin
                        state_reg <= B_ACC;
                    end else begin
                        op_reg    <= op_reg + 1'b1;
                        state_reg <= B_MUL;
                    end
                end
                B_ACC: begin
                    for (int m = 0; m < 4; m++) begin
                        acc_reg[m] <= sum[m][ACC_WIDTH-1:0];
                    end
                    sat_seen_reg <= sat_seen_reg | psat_reg | k12_sat | half_sat | add_sat;
                    state_reg    <= ent_reg.last ? B_EMIT : B_IDLE;
                end
                B_EMIT: begin
                    if (!out_valid_reg || out_ready) begin
                        for (int m = 0; m < 4; m++) begin
                            out_reg[m] <= acc_reg[m];
                            acc_reg[m] <= '0;
                        end
                        out_sat_reg   <= sat_seen_reg;
                        sat_seen_reg  <= 1'b0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/lennard_jones_pair_force_accumulator_top.sv =====
// lennard_jones_pair_force_accumulator_top: register port, front, queue and back
// depends on ljpf_pkg, ljpf_front, ljpf_queue, ljpf_back
`timescale 1ns / 1ps

// Accumulates 12-6 Lennard-Jones force and half pair energy of one home atom
// over a stream of neighbour pair requests, and emits the four saturated sums
// and a sticky saturation flag on the request marked by s_tlast. The front
// takes one request at a time (capture, difference, three squares on one
// multiplier, classify) and holds it while the queue is full. The back is the
// limit: a pair outside the cutoff is only taken over there, a pair inside is
// taken over, then runs the bit-serial reciprocal, ten multiplies on one 32x32
// multiplier built from partial products and one accumulate step; the last
// request of a run adds an emit step.
// A two-entry queue between front and back lets the front take requests while
// the back works. Registers are to be written over the APB port only while
// the block is idle; the user is bound to this, as the block does no check.
module lennard_jones_pair_force_accumulator_top
    import ljpf_pkg::*;
#(
    parameter int IN_FRAC_BITS = 16,
    parameter int ACC_WIDTH    = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    // home_x, home_y, home_z, nbr_x, nbr_y, nbr_z, image_x, image_y, image_z
    input  logic [287:0] s_tdata,
    input  logic         s_tlast,
    input  logic         s_tvalid,
    output logic         s_tready,
    // force_x, force_y, force_z, energy, zero fill to whole bytes
    output logic [((4*ACC_WIDTH+7)/8)*8-1:0] m_tdata,
    // saturated
    output logic         m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int TDW = ((4*ACC_WIDTH+7)/8)*8;

    cfg_t      cfg_reg;
    logic      q_push, q_pop;
    pair_t     q_in, q_out;
    q_status_t q_status;
    logic [ACC_WIDTH-1:0] fx, fy, fz, en;

    // register port
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cutoff_sq    <= RST_CUTOFF_SQ;
            cfg_reg.sigma_pow6   <= RST_SIGMA_POW6;
            cfg_reg.energy_shift <= RST_ENERGY_SHIFT;
            cfg_reg.force_scale  <= RST_FORCE_SCALE;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_CUTOFF_SQ:    cfg_reg.cutoff_sq    <= pwdata;
                REG_SIGMA_POW6:   cfg_reg.sigma_pow6   <= pwdata;
                REG_ENERGY_SHIFT: cfg_reg.energy_shift <= pwdata;
                default:          cfg_reg.force_scale  <= pwdata;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CUTOFF_SQ:    prdata = cfg_reg.cutoff_sq;
            REG_SIGMA_POW6:   prdata = cfg_reg.sigma_pow6;
            REG_ENERGY_SHIFT: prdata = cfg_reg.energy_shift;
            default:          prdata = cfg_reg.force_scale;
        endcase
    end

    ljpf_front #(
        .IN_FRAC_BITS(IN_FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cutoff_sq (cfg_reg.cutoff_sq),
        .push      (q_push),
        .push_data (q_in),
        .q_status  (q_status)
    );

    ljpf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .status    (q_status)
    );

    ljpf_back #(
        .IN_FRAC_BITS(IN_FRAC_BITS),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_data    (q_out),
        .q_status  (q_status),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .force_x   (fx),
        .force_y   (fy),
        .force_z   (fz),
        .energy    (en),
        .saturated (m_tuser)
    );

    assign m_tdata = TDW'({en, fz, fy, fx});

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("queue pop while empty");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule
